// ===== sv/rke_pkg.sv =====
// Shared constants, types and exp table builders for the RBF kernel unit.
package rke_pkg;

    localparam int EXP_TABLE_BITS_DEF = 8;
    localparam int EXP_INT_LIMIT      = 21;
    localparam int FRAC_BITS          = 16;
    localparam int Q30_W              = 31;
    localparam int COORD_W            = 24;
    localparam int DIFF_W             = 25;
    localparam int R2_W               = 50;
    localparam int CFG_W              = 24;
    localparam int CFG_IDX_W          = 2;
    localparam int A_W                = 21;
    localparam int FIFO_DEPTH         = 8;
    localparam int FIFO_PTR_W         = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W         = FIFO_PTR_W + 1;
    localparam logic [CFG_W-1:0] CFG_ONE = 24'd65536;

    typedef logic [Q30_W-1:0] t_q30;
    typedef t_q30 t_int_tab [EXP_INT_LIMIT];
    typedef t_q30 t_fc_tab [FRAC_BITS+1];

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIG_VAR = 2'd0,
        CFG_LEN_SQ  = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [R2_W-1:0]          r2;
    } t_pair_item;

    // Q30 product, round half up
    function automatic t_q30 mul_q30(t_q30 a, t_q30 b);
        logic [2*Q30_W-1:0] p;
        p = {{Q30_W{1'b0}}, a} * {{Q30_W{1'b0}}, b} + (62'd1 << 29);
        return t_q30'(p >> 30);
    endfunction

    function automatic logic [63:0] div_k(logic [63:0] t, int k);
        case (k)
            2:       return t / 2;
            3:       return t / 3;
            4:       return t / 4;
            5:       return t / 5;
            6:       return t / 6;
            7:       return t / 7;
            8:       return t / 8;
            9:       return t / 9;
            10:      return t / 10;
            11:      return t / 11;
            12:      return t / 12;
            default: return t;
        endcase
    endfunction

    // exp(-2^-i) by a 13 term series
    function automatic t_q30 frac_const(int i);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << 30;
        sum  = term;
        for (int k = 1; k <= 12; k++) begin
            term = div_k(term >> i, k);
            if (k[0]) sum = sum - term;
            else      sum = sum + term;
        end
        return t_q30'(sum);
    endfunction

    function automatic t_fc_tab build_fc();
        t_fc_tab t;
        t[0] = t_q30'(64'd1 << 30);
        for (int i = 1; i <= FRAC_BITS; i++) t[i] = frac_const(i);
        return t;
    endfunction

    localparam t_fc_tab FRAC_C = build_fc();

    function automatic t_int_tab build_int();
        t_int_tab t;
        t_q30     e1;
        e1   = mul_q30(FRAC_C[1], FRAC_C[1]);
        t[0] = t_q30'(64'd1 << 30);
        for (int n = 1; n < EXP_INT_LIMIT; n++) t[n] = mul_q30(t[n-1], e1);
        return t;
    endfunction

    localparam t_int_tab INT_C = build_int();

    // fraction table entry: constants multiplied in from the highest set bit down
    function automatic t_q30 tab_entry(int k, int tb);
        t_q30 v;
        v = t_q30'(64'd1 << 30);
        for (int j = 11; j >= 0; j--) begin
            if (j < tb && ((k >> j) & 1) == 1) v = mul_q30(v, FRAC_C[tb - j]);
        end
        return v;
    endfunction

endpackage

// ===== sv/rke_intf.sv =====
// Valid/ready channels for point pairs and kernel results.
interface rke_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [rke_pkg::COORD_W-1:0]  point_x;
    logic signed [rke_pkg::COORD_W-1:0]  point_y;
    logic signed [rke_pkg::COORD_W-1:0]  basis_x;
    logic signed [rke_pkg::COORD_W-1:0]  basis_y;
    modport source (output valid, point_x, point_y, basis_x, basis_y, input ready);
    modport sink (input valid, point_x, point_y, basis_x, basis_y, output ready);
endinterface

interface rke_out_if;
    logic               valid;
    logic               ready;
    logic        [30:0] cov_value;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic        [16:0] dtheta_variance;
    logic        [30:0] dtheta_length;
    modport source (output valid, cov_value, grad_x, grad_y, dtheta_variance, dtheta_length,
                    input ready);
    modport sink (input valid, cov_value, grad_x, grad_y, dtheta_variance, dtheta_length,
                  output ready);
endinterface

// ===== sv/rbf_kernel_eval_unit.sv =====
// RBF kernel evaluator top level: config registers, front end, queue, kernel pipeline.
// Pair word to result word passes the 21-bit exponent divide and the 32-bit derivative
//   divides, one bit a stage.
// Throughput: one pair per cycle; the whole back pipeline stalls while a result waits.
// Reset (synchronous, active low): queue and pipeline empty, variance and length scale 1.0.
module rbf_kernel_eval_unit #(
    parameter int EXP_TABLE_BITS = rke_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rke_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rke_pkg::CFG_W-1:0]       i_cfg_data,
    rke_in_if.sink                          i_pair,
    rke_out_if.source                       o_res
);
    logic [rke_pkg::CFG_W-1:0]       r_sig_var, r_len_sq;
    logic                            w_push, w_pop, w_empty;
    rke_pkg::t_pair_item             w_fin, w_fout;
    logic [rke_pkg::FIFO_CNT_W-1:0]  w_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_var <= rke_pkg::CFG_ONE;
            r_len_sq  <= rke_pkg::CFG_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rke_pkg::CFG_SIG_VAR: r_sig_var <= i_cfg_data;
                rke_pkg::CFG_LEN_SQ:  r_len_sq  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rke_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pair(i_pair),
        .i_fifo_cnt(w_cnt), .o_push(w_push), .o_item(w_fin)
    );

    rke_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_fin),
        .i_pop(w_pop), .o_data(w_fout), .o_empty(w_empty), .o_count(w_cnt)
    );

    rke_back #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sig_var(r_sig_var), .i_len_sq(r_len_sq),
        .i_item(w_fout), .i_empty(w_empty), .o_pop(w_pop), .o_res(o_res)
    );
endmodule

// ===== sv/rke_front.sv =====
// Front end: accepts pairs on credit, forms differences and squared distance.
module rke_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    rke_in_if.sink                             i_pair,
    input  logic [rke_pkg::FIFO_CNT_W-1:0]     i_fifo_cnt,
    output logic                               o_push,
    output rke_pkg::t_pair_item                o_item
);
    logic                              r_v1, r_v2, r_v3;
    logic signed [rke_pkg::DIFF_W-1:0] r_dx1, r_dy1, r_dx2, r_dy2, r_dx3, r_dy3;
    logic signed [rke_pkg::R2_W-1:0]   r_sx, r_sy;
    logic [rke_pkg::R2_W-1:0]          r_r2;
    logic [rke_pkg::FIFO_CNT_W:0]      w_used;
    logic                              w_acc;

    // every word in flight already owns a queue slot
    assign w_used = {1'b0, i_fifo_cnt} + (rke_pkg::FIFO_CNT_W + 1)'(r_v1)
                  + (rke_pkg::FIFO_CNT_W + 1)'(r_v2) + (rke_pkg::FIFO_CNT_W + 1)'(r_v3);
    assign i_pair.ready = w_used < (rke_pkg::FIFO_CNT_W + 1)'(rke_pkg::FIFO_DEPTH);
    assign w_acc = i_pair.valid && i_pair.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx1 <= {i_pair.point_x[23], i_pair.point_x} - {i_pair.basis_x[23], i_pair.basis_x};
        r_dy1 <= {i_pair.point_y[23], i_pair.point_y} - {i_pair.basis_y[23], i_pair.basis_y};
        r_sx  <= r_dx1 * r_dx1;
        r_sy  <= r_dy1 * r_dy1;
        r_dx2 <= r_dx1;
        r_dy2 <= r_dy1;
        r_r2  <= unsigned'(r_sx) + unsigned'(r_sy);
        r_dx3 <= r_dx2;
        r_dy3 <= r_dy2;
    end

    assign o_push    = r_v3;
    assign o_item.dx = r_dx3;
    assign o_item.dy = r_dy3;
    assign o_item.r2 = r_r2;
endmodule

// ===== sv/rke_fifo.sv =====
// Short queue between front end and kernel pipeline.
module rke_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  rke_pkg::t_pair_item                i_data,
    input  logic                               i_pop,
    output rke_pkg::t_pair_item                o_data,
    output logic                               o_empty,
    output logic [rke_pkg::FIFO_CNT_W-1:0]     o_count
);
    rke_pkg::t_pair_item                 r_mem [rke_pkg::FIFO_DEPTH];
    logic [rke_pkg::FIFO_PTR_W-1:0]      r_wr, r_rd;
    logic [rke_pkg::FIFO_CNT_W-1:0]      r_cnt;
    logic                                w_pop;

    assign o_empty = r_cnt == '0;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + rke_pkg::FIFO_CNT_W'(i_push) - rke_pkg::FIFO_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end
endmodule

// ===== sv/rke_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rke_div #(
    parameter int NumW  = 8,
    parameter int DenW  = 8,
    parameter int QuoW  = 8,
    parameter int SideW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NumW-1:0]  i_num,
    input  logic [DenW-1:0]  i_den,
    input  logic [SideW-1:0] i_side,
    output logic             o_valid,
    output logic [QuoW-1:0]  o_quo,
    output logic [DenW-1:0]  o_rem,
    output logic             o_ovf,
    output logic [SideW-1:0] o_side
);
    localparam int W = ((NumW > DenW + QuoW) ? NumW : DenW + QuoW) + 1;

    logic             r_vld  [QuoW+1];
    logic [W-1:0]     r_rem  [QuoW+1];
    logic [QuoW-1:0]  r_quo  [QuoW+1];
    logic             r_ovf  [QuoW+1];
    logic [SideW-1:0] r_side [QuoW+1];
    logic [W-1:0]     w_num, w_den;
    logic             w_ovf;

    assign w_num = W'(i_num);
    assign w_den = W'(i_den);
    assign w_ovf = w_num >= (w_den << QuoW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld[0] <= 1'b0;
        else if (i_en) r_vld[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_ovf ? '0 : w_num;
            r_quo[0]  <= '0;
            r_ovf[0]  <= w_ovf;
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 0; j < QuoW; j++) begin : g_stage
        logic [W-1:0] w_trial;
        logic         w_ge;
        assign w_trial = w_den << (QuoW - 1 - j);
        assign w_ge    = r_rem[j] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[j+1] <= 1'b0;
            else if (i_en) r_vld[j+1] <= r_vld[j];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= w_ge ? r_rem[j] - w_trial : r_rem[j];
                r_quo[j+1]  <= (r_quo[j] << 1) | QuoW'(w_ge);
                r_ovf[j+1]  <= r_ovf[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_vld[QuoW];
    assign o_quo   = r_quo[QuoW];
    assign o_rem   = DenW'(r_rem[QuoW]);
    assign o_ovf   = r_ovf[QuoW];
    assign o_side  = r_side[QuoW];
endmodule

// ===== sv/rke_exp.sv =====
// exp(-a) pipeline: integer and table lookup, then one stage per low fraction bit.
module rke_exp #(
    parameter int TableBits = rke_pkg::EXP_TABLE_BITS_DEF,
    parameter int SideW     = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [rke_pkg::A_W-1:0]   i_a,
    input  logic                      i_big,
    input  logic [SideW-1:0]          i_side,
    output logic                      o_valid,
    output rke_pkg::t_q30             o_ev,
    output logic [SideW-1:0]          o_side
);
    localparam int LowW    = rke_pkg::FRAC_BITS - TableBits;
    localparam int TabSize = 1 << TableBits;

    rke_pkg::t_q30     w_tab [TabSize];
    logic [4:0]        w_n;
    logic [TableBits-1:0] w_idx;

    logic              r_x_v;
    rke_pkg::t_q30     r_int, r_tab;
    logic [LowW-1:0]   r_x_low;
    logic              r_x_big;
    logic [SideW-1:0]  r_x_side;

    logic              r_vld  [LowW+1];
    rke_pkg::t_q30     r_v    [LowW+1];
    logic [LowW-1:0]   r_low  [LowW+1];
    logic              r_big  [LowW+1];
    logic [SideW-1:0]  r_side [LowW+1];

    for (genvar k = 0; k < TabSize; k++) begin : g_tab
        assign w_tab[k] = rke_pkg::tab_entry(k, TableBits);
    end

    assign w_n   = (i_a[20:16] >= 5'(rke_pkg::EXP_INT_LIMIT)) ? 5'd0 : i_a[20:16];
    assign w_idx = i_a[15 -: TableBits];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v    <= 1'b0;
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_x_v    <= i_valid;
            r_vld[0] <= r_x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_int     <= rke_pkg::INT_C[w_n];
            r_tab     <= w_tab[w_idx];
            r_x_low   <= i_a[LowW-1:0];
            r_x_big   <= i_big;
            r_x_side  <= i_side;
            r_v[0]    <= rke_pkg::mul_q30(r_int, r_tab);
            r_low[0]  <= r_x_low;
            r_big[0]  <= r_x_big;
            r_side[0] <= r_x_side;
        end
    end

    for (genvar k = 0; k < LowW; k++) begin : g_bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k+1] <= 1'b0;
            else if (i_en) r_vld[k+1] <= r_vld[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k+1]    <= r_low[k][LowW-1-k]
                             ? rke_pkg::mul_q30(r_v[k], rke_pkg::FRAC_C[TableBits+1+k])
                             : r_v[k];
                r_low[k+1]  <= r_low[k];
                r_big[k+1]  <= r_big[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[LowW];
    assign o_ev    = r_big[LowW] ? '0 : r_v[LowW];
    assign o_side  = r_side[LowW];
endmodule

// ===== sv/rke_back.sv =====
// Kernel pipeline: exponent divide, exp, scaling, derivative divides, output register.
module rke_back #(
    parameter int EXP_TABLE_BITS = rke_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rke_pkg::CFG_W-1:0]     i_sig_var,
    input  logic [rke_pkg::CFG_W-1:0]     i_len_sq,
    input  rke_pkg::t_pair_item           i_item,
    input  logic                          i_empty,
    output logic                          o_pop,
    rke_out_if.source                     o_res
);
    localparam int DW = rke_pkg::DIFF_W;
    localparam int AW = rke_pkg::A_W;
    localparam logic [AW-1:0] BigK = AW'(rke_pkg::EXP_INT_LIMIT << rke_pkg::FRAC_BITS);

    logic                 w_en;
    logic [23:0]          w_l;
    logic [56:0]          w_num0;
    logic                 w_big0;

    logic                 r0_v, r0_big;
    logic [56:0]          r0_num;
    logic signed [DW-1:0] r0_dx, r0_dy;

    logic                 w_av;
    logic [AW-1:0]        w_a;
    logic [2*DW:0]        w_sa;
    logic                 w_ev_v;
    rke_pkg::t_q30        w_ev;
    logic [2*DW+AW-1:0]   w_se;

    logic                 r_m_v;
    logic [54:0]          r_m_p;
    rke_pkg::t_q30        r_m_ev;
    logic signed [DW-1:0] r_m_dx, r_m_dy;
    logic [AW-1:0]        r_m_a;

    logic                 r_n_v, r_n_negx, r_n_negy;
    logic [40:0]          r_n_se;
    logic [30:0]          r_n_cov;
    logic [16:0]          r_n_eo;
    logic [DW-1:0]        r_n_mx, r_n_my;
    logic [AW-1:0]        r_n_a;

    logic                 r_p_v, r_p_negx, r_p_negy;
    logic [45:0]          r_p_xh, r_p_yh;
    logic [44:0]          r_p_xl, r_p_yl;
    logic [41:0]          r_p_ah;
    logic [40:0]          r_p_al;
    logic [30:0]          r_p_cov;
    logic [16:0]          r_p_eo;

    logic                 r_q_v, r_q_negx, r_q_negy;
    logic [65:0]          r_q_px, r_q_py;
    logic [61:0]          r_q_pa;
    logic [30:0]          r_q_cov;
    logic [16:0]          r_q_eo;

    logic                 w_d_v, w_gx_ovf, w_gy_ovf, w_dl_ovf, w_negx, w_negy;
    logic [31:0]          w_gx_q, w_gy_q, w_dl_q;
    logic [35:0]          w_gx_r, w_gy_r, w_gden;
    logic [39:0]          w_dl_r, w_lden;
    logic [47:0]          w_dl_side;
    logic [32:0]          w_dl_qr;

    logic                 r_ov;
    logic [30:0]          r_o_cov, r_o_dlen;
    logic [31:0]          r_o_gx, r_o_gy;
    logic [16:0]          r_o_eo;

    function automatic logic [31:0] grad_fin(logic [31:0] q, logic rnd, logic ovf, logic neg);
        logic [32:0] qr;
        qr = {1'b0, q} + 33'(rnd);
        if (neg) begin
            if (ovf || qr > 33'h080000000) qr = 33'h080000000;
            return 32'(33'd0 - qr);
        end
        if (ovf || qr > 33'h07FFFFFFF) qr = 33'h07FFFFFFF;
        return qr[31:0];
    endfunction

    // whole pipeline advances whenever the output register can take a word
    assign w_en  = !r_ov || o_res.ready;
    assign o_pop = w_en && !i_empty;

    assign w_l    = (i_len_sq == '0) ? 24'd1 : i_len_sq;
    assign w_num0 = {i_item.r2, 7'b0};
    // a >= 21.0 gives e = 0: drop the divide and zero the exp
    assign w_big0 = w_num0 >= (57'(w_l) * 57'(BigK));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v  <= 1'b0;
            r_m_v <= 1'b0;
            r_n_v <= 1'b0;
            r_p_v <= 1'b0;
            r_q_v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r0_v  <= !i_empty;
            r_m_v <= w_ev_v;
            r_n_v <= r_m_v;
            r_p_v <= r_n_v;
            r_q_v <= r_p_v;
            r_ov  <= w_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_num <= w_big0 ? '0 : w_num0;
            r0_big <= w_big0;
            r0_dx  <= i_item.dx;
            r0_dy  <= i_item.dy;
        end
    end

    rke_div #(.NumW(57), .DenW(24), .QuoW(AW), .SideW(2*DW+1)) u_div_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r0_v),
        .i_num(r0_num), .i_den(w_l), .i_side({r0_big, r0_dx, r0_dy}),
        .o_valid(w_av), .o_quo(w_a), .o_rem(), .o_ovf(), .o_side(w_sa)
    );

    rke_exp #(.TableBits(EXP_TABLE_BITS), .SideW(2*DW+AW)) u_exp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_av),
        .i_a(w_a), .i_big(w_sa[2*DW]), .i_side({w_sa[2*DW-1:0], w_a}),
        .o_valid(w_ev_v), .o_ev(w_ev), .o_side(w_se)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_p  <= 55'(i_sig_var) * 55'(w_ev);
            r_m_ev <= w_ev;
            r_m_dx <= w_se[2*DW+AW-1 -: DW];
            r_m_dy <= w_se[DW+AW-1 -: DW];
            r_m_a  <= w_se[AW-1:0];

            r_n_se   <= 41'((r_m_p + 55'(1 << 13)) >> 14);
            r_n_cov  <= 31'((r_m_p + 55'(1 << 29)) >> 30);
            r_n_eo   <= 17'((r_m_ev + 31'(1 << 13)) >> 14);
            r_n_mx   <= r_m_dx[DW-1] ? DW'(-r_m_dx) : r_m_dx;
            r_n_my   <= r_m_dy[DW-1] ? DW'(-r_m_dy) : r_m_dy;
            r_n_negx <= !r_m_dx[DW-1] && (r_m_dx != '0);
            r_n_negy <= !r_m_dy[DW-1] && (r_m_dy != '0);
            r_n_a    <= r_m_a;

            // se is 41 bits: split into 21 + 20 bit halves
            r_p_xh   <= 46'(r_n_se[40:20]) * 46'(r_n_mx);
            r_p_xl   <= 45'(r_n_se[19:0]) * 45'(r_n_mx);
            r_p_yh   <= 46'(r_n_se[40:20]) * 46'(r_n_my);
            r_p_yl   <= 45'(r_n_se[19:0]) * 45'(r_n_my);
            r_p_ah   <= 42'(r_n_se[40:20]) * 42'(r_n_a);
            r_p_al   <= 41'(r_n_se[19:0]) * 41'(r_n_a);
            r_p_negx <= r_n_negx;
            r_p_negy <= r_n_negy;
            r_p_cov  <= r_n_cov;
            r_p_eo   <= r_n_eo;

            r_q_px   <= (66'(r_p_xh) << 20) + 66'(r_p_xl);
            r_q_py   <= (66'(r_p_yh) << 20) + 66'(r_p_yl);
            r_q_pa   <= (62'(r_p_ah) << 20) + 62'(r_p_al);
            r_q_negx <= r_p_negx;
            r_q_negy <= r_p_negy;
            r_q_cov  <= r_p_cov;
            r_q_eo   <= r_p_eo;
        end
    end

    assign w_gden = {w_l, 12'b0};
    assign w_lden = {w_l, 16'b0};

    rke_div #(.NumW(66), .DenW(36), .QuoW(32), .SideW(1)) u_div_gx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_q_v),
        .i_num(r_q_px), .i_den(w_gden), .i_side(r_q_negx),
        .o_valid(w_d_v), .o_quo(w_gx_q), .o_rem(w_gx_r), .o_ovf(w_gx_ovf), .o_side(w_negx)
    );

    rke_div #(.NumW(66), .DenW(36), .QuoW(32), .SideW(1)) u_div_gy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_q_v),
        .i_num(r_q_py), .i_den(w_gden), .i_side(r_q_negy),
        .o_valid(), .o_quo(w_gy_q), .o_rem(w_gy_r), .o_ovf(w_gy_ovf), .o_side(w_negy)
    );

    rke_div #(.NumW(62), .DenW(40), .QuoW(32), .SideW(48)) u_div_dl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_q_v),
        .i_num(r_q_pa), .i_den(w_lden), .i_side({r_q_cov, r_q_eo}),
        .o_valid(), .o_quo(w_dl_q), .o_rem(w_dl_r), .o_ovf(w_dl_ovf), .o_side(w_dl_side)
    );

    // round half up: 2*rem >= den
    assign w_dl_qr = {1'b0, w_dl_q} + 33'({w_dl_r, 1'b0} >= {1'b0, w_lden});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_gx   <= grad_fin(w_gx_q, {w_gx_r, 1'b0} >= {1'b0, w_gden}, w_gx_ovf, w_negx);
            r_o_gy   <= grad_fin(w_gy_q, {w_gy_r, 1'b0} >= {1'b0, w_gden}, w_gy_ovf, w_negy);
            r_o_dlen <= (w_dl_ovf || w_dl_qr > 33'h07FFFFFFF) ? 31'h7FFFFFFF : w_dl_qr[30:0];
            r_o_cov  <= w_dl_side[47:17];
            r_o_eo   <= w_dl_side[16:0];
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.cov_value       = r_o_cov;
    assign o_res.grad_x          = r_o_gx;
    assign o_res.grad_y          = r_o_gy;
    assign o_res.dtheta_variance = r_o_eo;
    assign o_res.dtheta_length   = r_o_dlen;
endmodule
